// ===== hdl/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared constants, types and helpers for the separable clamped blur.
// ----------------------------------------------------------------------------
package sgb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 4;
  localparam int RING       = 2 * MAX_RADIUS + 1;

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = 11;
  localparam int RAD_W  = 3;
  localparam int PIX_W  = 16;
  localparam int TAP_W  = 16;
  localparam int RW     = $clog2(RING);
  localparam int TW     = $clog2(2 * MAX_RADIUS + 1);
  localparam int ADDR_W = RW + XW;
  localparam int PROD_W = PIX_W + TAP_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_RADIUS       = 3'd2;
  localparam logic [CFG_IW-1:0] REG_TAP_CENTER   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TAP_ONE      = 3'd4;
  localparam logic [CFG_IW-1:0] REG_TAP_TWO      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_TAP_THREE    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_TAP_FOUR     = 3'd7;

  // effective (clamped) configuration
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [XW-1:0]    wm1;
    logic [YW-1:0]    hm1;
    logic [RAD_W-1:0] r;
    logic [TAP_W-1:0] tap0;
    logic [TAP_W-1:0] tap1;
    logic [TAP_W-1:0] tap2;
    logic [TAP_W-1:0] tap3;
    logic [TAP_W-1:0] tap4;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ram_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic [XW-1:0]    x;
    logic [YW-1:0]    y;
    logic [PIX_W-1:0] pix;
    logic             run_last;
    logic             frame_done;
  } result_t;

  function automatic logic [TAP_W-1:0] tap_at(cfg_t c, logic [RAD_W-1:0] d);
    logic [TAP_W-1:0] t;
    case (d)
      3'd0:    t = c.tap0;
      3'd1:    t = c.tap1;
      3'd2:    t = c.tap2;
      3'd3:    t = c.tap3;
      3'd4:    t = c.tap4;
      default: t = '0;
    endcase
    return t;
  endfunction

  // round away the 16 fraction bits of the Q0.16 taps, to nearest, half up, saturate to 16 bits
  function automatic logic [PIX_W-1:0] round_sat(logic [ACC_W-1:0] acc);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W+1)'(32768);
    if (|s[ACC_W:32]) return '1;
    return s[31:16];
  endfunction

endpackage

// ===== hdl/separable_gaussian_blur_clamped_unit.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_clamped_unit
// Operation: an item with no horizontal result leaves the input ready; otherwise
//   up to r+1 columns are filtered horizontally into the line store, then each
//   result is built through the line store read port and held for the output.
// The input stalls until every result of an item has been taken, so a new item
//   is accepted only when the engine is idle.
// Reset: synchronous, active low; clears counters, row window and handshakes.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_clamped_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [9:0]                  out_out_x,
  output logic [9:0]                  out_out_y,
  output logic [15:0]                 out_pixel_out,
  output logic                        out_run_last,
  output logic                        out_frame_done,
  input  logic                        cfg_we,
  input  logic [sgb_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sgb_pkg::CFG_DW-1:0]  cfg_data
);
  import sgb_pkg::*;

  cfg_t             cfg;
  ram_wr_t          ram_wr;
  ram_rd_t          ram_rd;
  logic [PIX_W-1:0] ram_rdata;
  logic             res_valid, res_take;
  result_t          res;
  logic             out_valid_r, out_valid_nxt;
  result_t          out_r;

  sgb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sgb_line_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_rdata)
  );

  sgb_engine u_eng (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_pixel  (in_pixel_in),
    .in_stall  (in_stall),
    .ram_wr    (ram_wr),
    .ram_rd    (ram_rd),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_take) out_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_out_x      = out_r.x;
  assign out_out_y      = out_r.y;
  assign out_pixel_out  = out_r.pix;
  assign out_run_last   = out_r.run_last;
  assign out_frame_done = out_r.frame_done;

  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr.we && ram_rd.re))
    else $error("line store written and read in one cycle");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_done |-> out_r.run_last)
    else $error("frame end not marked as end of run");

  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid_r)
    else $error("result taken but output register empty");

endmodule

// ===== hdl/sgb_line_ram.sv =====
// ----------------------------------------------------------------------------
// sgb_line_ram
// Line store: horizontal results of the last rows, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module sgb_line_ram (
  input  logic                 clk,
  input  sgb_pkg::ram_wr_t     wr,
  input  sgb_pkg::ram_rd_t     rd,
  output logic [15:0]          rdata
);
  import sgb_pkg::*;

  logic [PIX_W-1:0] mem [RING*MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.re) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

// ===== hdl/sgb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sgb_cfg_regs
// Configuration registers with range clamping of size and radius.
// ----------------------------------------------------------------------------
module sgb_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sgb_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sgb_pkg::CFG_DW-1:0]  cfg_data,
  output sgb_pkg::cfg_t               cfg
);
  import sgb_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [RAD_W-1:0] radius_r;
  logic [TAP_W-1:0] tap0_r, tap1_r, tap2_r, tap3_r, tap4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(MAX_HEIGHT);
      radius_r <= RAD_W'(MAX_RADIUS);
      tap0_r   <= 16'd21791;
      tap1_r   <= 16'd15396;
      tap2_r   <= 16'd5434;
      tap3_r   <= 16'd957;
      tap4_r   <= 16'd84;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_RADIUS:       radius_r <= cfg_data[RAD_W-1:0];
        REG_TAP_CENTER:   tap0_r   <= cfg_data[TAP_W-1:0];
        REG_TAP_ONE:      tap1_r   <= cfg_data[TAP_W-1:0];
        REG_TAP_TWO:      tap2_r   <= cfg_data[TAP_W-1:0];
        REG_TAP_THREE:    tap3_r   <= cfg_data[TAP_W-1:0];
        REG_TAP_FOUR:     tap4_r   <= cfg_data[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.w = (width_r == '0) ? DIM_W'(1) :
            (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
    cfg.h = (height_r == '0) ? DIM_W'(1) :
            (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;
    cfg.r = (radius_r == '0) ? RAD_W'(1) :
            (radius_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_r;
    cfg.wm1  = XW'(cfg.w - DIM_W'(1));
    cfg.hm1  = YW'(cfg.h - DIM_W'(1));
    cfg.tap0 = tap0_r;
    cfg.tap1 = tap1_r;
    cfg.tap2 = tap2_r;
    cfg.tap3 = tap3_r;
    cfg.tap4 = tap4_r;
  end

endmodule

// ===== hdl/sgb_engine.sv =====
// ----------------------------------------------------------------------------
// sgb_engine
// Sequencer: row window, horizontal MAC into the line store, vertical MAC
// out of the line store, one result at a time.
// ----------------------------------------------------------------------------
module sgb_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgb_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  input  logic [sgb_pkg::PIX_W-1:0]   in_pixel,
  output logic                        in_stall,
  output sgb_pkg::ram_wr_t            ram_wr,
  output sgb_pkg::ram_rd_t            ram_rd,
  input  logic [sgb_pkg::PIX_W-1:0]   ram_rdata,
  output logic                        res_valid,
  output sgb_pkg::result_t            res,
  input  logic                        res_take
);
  import sgb_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HORIZ = 2'd1;
  localparam logic [1:0] ST_VERT  = 2'd2;
  localparam logic [1:0] ST_VOUT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [XW-1:0]    col_r, col_nxt;
  logic [YW-1:0]    row_r, row_nxt;
  logic [RW-1:0]    ring_r, ring_nxt;
  logic [XW-1:0]    cx_r, cx_nxt, x0_r, x0_nxt, x1_r, x1_nxt;
  logic [YW-1:0]    cy_r, cy_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [RW-1:0]    cyring_r, cyring_nxt;
  logic             have_y_r, have_y_nxt;
  logic [XW-1:0]    hx_r, hx_nxt, vx_r, vx_nxt;
  logic [YW-1:0]    vy_r, vy_nxt;
  logic [TW-1:0]    t_r, t_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             iss_r, iss_nxt;
  logic             pend_r, pend_nxt, first_r, first_nxt, last_r, last_nxt;
  logic [TAP_W-1:0] rtap_r, rtap_nxt;
  logic [PIX_W-1:0] res_r, res_nxt;
  logic [PIX_W-1:0] win_r [RING];

  // accept-time decode
  logic             accept;
  logic [XW-1:0]    cx, xr, x0, x1;
  logic [YW-1:0]    cy, yr, y0, y1;
  logic [RW-1:0]    cyring;
  logic             have_x, have_y;

  // shared tap walk
  logic [TW-1:0]    t_last;
  logic [RAD_W-1:0] tap_d;

  // horizontal
  logic signed [XW+1:0] hj_s;
  logic [XW-1:0]    hj, hback_w;
  logic [RW-1:0]    hback;
  logic [PROD_W-1:0] h_prod;
  logic [ACC_W-1:0] h_sum;

  // vertical
  logic signed [YW+1:0] vj_s;
  logic [YW-1:0]    vj, vdiff_w;
  logic [RW-1:0]    vdiff, vring;
  logic [PROD_W-1:0] v_prod;
  logic [ACC_W-1:0] v_sum;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cx     = ({1'b0, col_r} >= cfg.w) ? '0 : col_r;
    cy     = ({1'b0, row_r} >= cfg.h) ? '0 : row_r;
    cyring = ({1'b0, row_r} >= cfg.h) ? '0 : ring_r;
    xr     = XW'(cfg.r);
    yr     = YW'(cfg.r);
    have_x = 1'b1;
    if (cx == cfg.wm1) begin
      x0 = (cfg.wm1 >= xr) ? cfg.wm1 - xr : '0;
      x1 = cfg.wm1;
    end else if (cx >= xr) begin
      x0 = cx - xr;
      x1 = x0;
    end else begin
      have_x = 1'b0;
      x0 = '0;
      x1 = '0;
    end
    have_y = 1'b1;
    if (cy == cfg.hm1) begin
      y0 = (cfg.hm1 >= yr) ? cfg.hm1 - yr : '0;
      y1 = cfg.hm1;
    end else if (cy >= yr) begin
      y0 = cy - yr;
      y1 = y0;
    end else begin
      have_y = 1'b0;
      y0 = '0;
      y1 = '0;
    end
  end

  always_comb begin
    t_last = TW'({cfg.r, 1'b0});
    tap_d  = (t_r >= TW'(cfg.r)) ? RAD_W'(t_r - TW'(cfg.r)) : RAD_W'(TW'(cfg.r) - t_r);

    // horizontal tap: column clamped to the frame, then to the window
    hj_s = $signed({2'b00, hx_r}) + $signed((XW+2)'(t_r)) - $signed((XW+2)'(cfg.r));
    if (hj_s < 0) hj = '0;
    else if (hj_s > $signed({2'b00, cfg.wm1})) hj = cfg.wm1;
    else hj = hj_s[XW-1:0];
    hback_w = (hj <= cx_r) ? cx_r - hj : '0;
    hback   = (hback_w >= XW'(RING - 1)) ? RW'(RING - 1) : hback_w[RW-1:0];
    h_prod  = win_r[hback] * tap_at(cfg, tap_d);
    h_sum   = ((t_r == '0) ? '0 : acc_r) + ACC_W'(h_prod);

    // vertical tap: row clamped to the frame, mapped onto the ring
    vj_s = $signed({2'b00, vy_r}) + $signed((YW+2)'(t_r)) - $signed((YW+2)'(cfg.r));
    if (vj_s < 0) vj = '0;
    else if (vj_s > $signed({2'b00, cfg.hm1})) vj = cfg.hm1;
    else vj = vj_s[YW-1:0];
    vdiff_w = cy_r - vj;
    vdiff   = vdiff_w[RW-1:0];
    vring   = (cyring_r >= vdiff) ? cyring_r - vdiff :
              RW'({1'b0, cyring_r} + (RW+1)'(RING) - {1'b0, vdiff});
    v_prod  = ram_rdata * rtap_r;
    v_sum   = (first_r ? '0 : acc_r) + ACC_W'(v_prod);
  end

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    ring_nxt   = ring_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cyring_nxt = cyring_r;
    x0_nxt     = x0_r;
    x1_nxt     = x1_r;
    y0_nxt     = y0_r;
    y1_nxt     = y1_r;
    have_y_nxt = have_y_r;
    hx_nxt     = hx_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    t_nxt      = t_r;
    acc_nxt    = acc_r;
    iss_nxt    = iss_r;
    pend_nxt   = 1'b0;
    first_nxt  = first_r;
    last_nxt   = last_r;
    rtap_nxt   = rtap_r;
    res_nxt    = res_r;
    ram_wr.we   = 1'b0;
    ram_wr.addr = {cyring_r, hx_r};
    ram_wr.data = round_sat(h_sum);
    ram_rd.re   = 1'b0;
    ram_rd.addr = {vring, vx_r};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cx_nxt     = cx;
          cy_nxt     = cy;
          cyring_nxt = cyring;
          x0_nxt     = x0;
          x1_nxt     = x1;
          y0_nxt     = y0;
          y1_nxt     = y1;
          have_y_nxt = have_y;
          hx_nxt     = x0;
          t_nxt      = '0;
          if (cx == cfg.wm1) begin
            col_nxt = '0;
            if (cy == cfg.hm1) begin
              row_nxt  = '0;
              ring_nxt = '0;
            end else begin
              row_nxt  = cy + YW'(1);
              ring_nxt = (cyring == RW'(RING - 1)) ? '0 : cyring + RW'(1);
            end
          end else begin
            col_nxt  = cx + XW'(1);
            row_nxt  = cy;
            ring_nxt = cyring;
          end
          if (have_x) state_nxt = ST_HORIZ;
        end
      end
      ST_HORIZ: begin
        acc_nxt = h_sum;
        if (t_r == t_last) begin
          ram_wr.we = 1'b1;
          t_nxt     = '0;
          if (hx_r == x1_r) begin
            if (have_y_r) begin
              state_nxt = ST_VERT;
              vx_nxt    = x0_r;
              vy_nxt    = y0_r;
              iss_nxt   = 1'b1;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            hx_nxt = hx_r + XW'(1);
          end
        end else begin
          t_nxt = t_r + TW'(1);
        end
      end
      ST_VERT: begin
        if (iss_r) begin
          ram_rd.re = 1'b1;
          pend_nxt  = 1'b1;
          first_nxt = (t_r == '0);
          last_nxt  = (t_r == t_last);
          rtap_nxt  = tap_at(cfg, tap_d);
          t_nxt     = t_r + TW'(1);
          if (t_r == t_last) iss_nxt = 1'b0;
        end
        if (pend_r) begin
          acc_nxt = v_sum;
          if (last_r) begin
            res_nxt   = round_sat(v_sum);
            state_nxt = ST_VOUT;
          end
        end
      end
      ST_VOUT: begin
        if (res_take) begin
          t_nxt = '0;
          if (vx_r == x1_r) begin
            if (vy_r == y1_r) begin
              state_nxt = ST_IDLE;
            end else begin
              vy_nxt    = vy_r + YW'(1);
              vx_nxt    = x0_r;
              iss_nxt   = 1'b1;
              state_nxt = ST_VERT;
            end
          end else begin
            vx_nxt    = vx_r + XW'(1);
            iss_nxt   = 1'b1;
            state_nxt = ST_VERT;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res_valid      = (state_r == ST_VOUT);
  assign res.x          = vx_r;
  assign res.y          = vy_r;
  assign res.pix        = res_r;
  assign res.run_last   = (vx_r == x1_r) && (vy_r == y1_r);
  assign res.frame_done = (vx_r == cfg.wm1) && (vy_r == cfg.hm1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      ring_r  <= '0;
      iss_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ring_r  <= ring_nxt;
      iss_r   <= iss_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cyring_r <= cyring_nxt;
    x0_r     <= x0_nxt;
    x1_r     <= x1_nxt;
    y0_r     <= y0_nxt;
    y1_r     <= y1_nxt;
    have_y_r <= have_y_nxt;
    hx_r     <= hx_nxt;
    vx_r     <= vx_nxt;
    vy_r     <= vy_nxt;
    t_r      <= t_nxt;
    acc_r    <= acc_nxt;
    first_r  <= first_nxt;
    last_r   <= last_nxt;
    rtap_r   <= rtap_nxt;
    res_r    <= res_nxt;
  end

  // row window; cleared at the start of every row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RING; k++) win_r[k] <= '0;
    end else if (accept) begin
      win_r[0] <= in_pixel;
      for (int k = 1; k < RING; k++) win_r[k] <= (cx == '0) ? '0 : win_r[k-1];
    end
  end

endmodule

// ===== dv/separable_gaussian_blur_clamped_unit_tb.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_clamped_unit_tb
// Self-checking bench for the clamped separable blur. Whole frames are fed
// under a series of register settings. A directed table covers 1x1 frames
// with saturating taps, a frame narrower than the kernel, and pixel extremes.
// Random frames follow, some with out-of-range sizes and radii. Every result
// item is checked against an in-bench predictor (typed table rows give the
// expected pixel directly), and both channels idle at random.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_clamped_unit_tb;
  import sgb_pkg::*;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] pix;
    logic        run_last;
    logic        frame_done;
  } blur_res_t;

  typedef struct {
    logic [15:0] pix;
    bit          typed;
    logic [15:0] exp_pix;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_pixel_in;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_out_x;
  logic [9:0]  out_out_y;
  logic [15:0] out_pixel_out;
  logic        out_run_last;
  logic        out_frame_done;
  logic        cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  separable_gaussian_blur_clamped_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_out_x(out_out_x), .out_out_y(out_out_y), .out_pixel_out(out_pixel_out),
    .out_run_last(out_run_last), .out_frame_done(out_frame_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [10:0] m_w, m_h;
  logic [2:0]  m_r;
  logic [15:0] m_tap [5];
  int unsigned col_cnt, row_cnt;
  logic [15:0] win [9];
  logic [15:0] lstore [9][1024];

  blur_res_t exp_q[$];
  blur_res_t step_q[$];
  int n_bad;
  int burst_left, rand_items;
  bit hold_go;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200000000;
    $display("separable_gaussian_blur_clamped_unit regression: fail");
    $finish;
  end

  function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned tap_of(int unsigned d);
    if (d <= 4) return m_tap[d];
    return 0;
  endfunction

  function automatic logic [15:0] round_clip(longint unsigned acc);
    longint unsigned v;
    v = (acc + 32768) >> 16;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] hpass(int x, int cx, int w, int r);
    longint unsigned acc;
    int j, bk;
    acc = 0;
    for (int i = -r; i <= r; i++) begin
      j = x + i;
      if (j < 0) j = 0;
      if (j > w - 1) j = w - 1;
      bk = (j <= cx) ? cx - j : 0;
      if (bk >= 9) bk = 8;
      acc += longint'(win[bk]) * tap_of((i < 0) ? -i : i);
    end
    return round_clip(acc);
  endfunction

  function automatic logic [15:0] vpass(int x, int y, int h, int r);
    longint unsigned acc;
    int yy;
    acc = 0;
    for (int i = -r; i <= r; i++) begin
      yy = y + i;
      if (yy < 0) yy = 0;
      if (yy > h - 1) yy = h - 1;
      acc += longint'(lstore[yy % 9][x % 1024]) * tap_of((i < 0) ? -i : i);
    end
    return round_clip(acc);
  endfunction

  // predicts the result items of one accepted pixel into step_q
  task automatic blur_step(input logic [15:0] p);
    int w, h, r, cx, cy, x0, x1, y0, y1;
    bit hx, hy;
    blur_res_t e;
    w = clampv(m_w, 1, 1024);
    h = clampv(m_h, 1, 1024);
    r = clampv(m_r, 1, 4);
    step_q.delete();
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    cx = col_cnt;
    cy = row_cnt;
    if (cx == 0) foreach (win[k]) win[k] = '0;
    for (int k = 8; k > 0; k--) win[k] = win[k-1];
    win[0] = p;
    hx = 1;
    if (cx == w - 1) begin
      x0 = (w - 1 >= r) ? w - 1 - r : 0;
      x1 = w - 1;
    end else if (cx >= r) begin
      x0 = cx - r;
      x1 = x0;
    end else begin
      hx = 0; x0 = 1; x1 = 0;
    end
    if (hx)
      for (int x = x0; x <= x1; x++) lstore[cy % 9][x % 1024] = hpass(x, cx, w, r);
    hy = 1;
    if (cy == h - 1) begin
      y0 = (h - 1 >= r) ? h - 1 - r : 0;
      y1 = h - 1;
    end else if (cy >= r) begin
      y0 = cy - r;
      y1 = y0;
    end else begin
      hy = 0; y0 = 1; y1 = 0;
    end
    if (hx && hy) begin
      for (int y = y0; y <= y1; y++)
        for (int x = x0; x <= x1; x++) begin
          e.x = x[9:0];
          e.y = y[9:0];
          e.pix = vpass(x, y, h, r);
          e.run_last = 0;
          e.frame_done = (x == w - 1) && (y == h - 1);
          step_q = {step_q, e};
        end
      if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1;
    end
    col_cnt = cx + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = cy + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  task automatic set_regs(input logic [10:0] w, input logic [10:0] h, input logic [2:0] r,
                          input logic [15:0] t0, t1, t2, t3, t4);
    logic [15:0] vals [8];
    vals = '{16'(w), 16'(h), 16'(r), t0, t1, t2, t3, t4};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[CFG_IW-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_w = w; m_h = h; m_r = r;
    m_tap = '{t0, t1, t2, t3, t4};
  endtask

  // returns once the pixel has been taken; valid stays up within a burst
  task automatic send_pixel(input logic [15:0] p, input bit typed, input logic [15:0] tv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    in_pixel_in <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    blur_step(p);
    foreach (step_q[k]) begin
      if (typed) step_q[k].pix = tv;
      exp_q = {exp_q, step_q[k]};
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_frames(input logic [10:0] w, input logic [10:0] h, input logic [2:0] r,
                            input int frames);
    int n;
    set_regs(w, h, r, rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    n = clampv(w, 1, 1024) * clampv(h, 1, 1024) * frames;
    for (int i = 0; i < n; i++) begin
      send_pixel(rand_word(), 0, '0);
      rand_items++;
    end
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result item x=%0d y=%0d pix=%h", out_out_x, out_out_y,
                   out_pixel_out);
      end else begin
        blur_res_t e;
        e = exp_q.pop_front();
        if (out_out_x !== e.x || out_out_y !== e.y || out_pixel_out !== e.pix ||
            out_run_last !== e.run_last || out_frame_done !== e.frame_done) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"mismatch: exp x=%0d y=%0d pix=%h last=%b done=%b, ",
                      "got x=%0d y=%0d pix=%h last=%b done=%b"},
                     e.x, e.y, e.pix, e.run_last, e.frame_done, out_out_x, out_out_y,
                     out_pixel_out, out_run_last, out_frame_done);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int pct, hold;
    pct = 0;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && hold == 0) begin
        hold = 600;
        hold_go = 0;
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 60;
          default: pct = 90;
        endcase
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else
        out_stall <= ($urandom_range(0, 99) < pct);
    end
  end

  dir_row_t dir_tab [15] = '{
    // 1x1 frames, all taps at full scale
    '{16'h0000, 1, 16'h0000}, '{16'hFFFF, 1, 16'hFFFF}, '{16'h0001, 0, 16'h0000},
    // 4x3 frame, radius larger than the frame
    '{16'hFFFF, 0, 0}, '{16'h0000, 0, 0}, '{16'h8000, 0, 0}, '{16'h7FFF, 0, 0},
    '{16'h00FF, 0, 0}, '{16'hFF00, 0, 0}, '{16'hAAAA, 0, 0}, '{16'h5555, 0, 0},
    '{16'hFFFF, 0, 0}, '{16'hFFFF, 0, 0}, '{16'h0001, 0, 0}, '{16'h1234, 0, 0}
  };

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_bad = 0;
    burst_left = 0;
    rand_items = 0;
    hold_go = 0;
    m_w = 11'd1024; m_h = 11'd1024; m_r = 3'd4;
    m_tap = '{16'd21791, 16'd15396, 16'd5434, 16'd957, 16'd84};
    col_cnt = 0; row_cnt = 0;
    foreach (win[k]) win[k] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(11'd1, 11'd1, 3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].exp_pix);
    drain();
    set_regs(11'd4, 11'd3, 3'd4, 16'd21791, 16'd15396, 16'd5434, 16'd957, 16'd84);
    for (int i = 3; i < 15; i++) send_pixel(dir_tab[i].pix, dir_tab[i].typed, dir_tab[i].exp_pix);
    drain();

    // start of an over-wide single row, then restart under a new size
    set_regs(11'd2047, 11'd1, 3'd7, rand_word(), rand_word(), rand_word(), rand_word(),
             rand_word());
    for (int i = 0; i < 40; i++) send_pixel(rand_word(), 0, '0);
    drain();

    // out-of-range register values
    run_frames(11'd1, 11'd30, 3'd0, 1);
    run_frames(11'd0, 11'd0, 3'd3, 2);
    rand_items = 0;
    hold_go = 1;
    while (rand_items < 180) begin
      logic [10:0] w, h;
      w = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 16)) : 11'($urandom_range(1, 9));
      h = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 12)) : 11'($urandom_range(1, 9));
      run_frames(w, h, 3'($urandom_range(0, 7)), $urandom_range(1, 2));
    end

    drain();
    if (n_bad == 0 && exp_q.size() == 0)
      $display("separable_gaussian_blur_clamped_unit regression: pass");
    else
      $display("separable_gaussian_blur_clamped_unit regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sgb_pkg.sv
hdl/sgb_line_ram.sv
hdl/sgb_cfg_regs.sv
hdl/sgb_engine.sv
hdl/separable_gaussian_blur_clamped_unit.sv
dv/separable_gaussian_blur_clamped_unit_tb.sv
